### rtl/lkp_pkg.sv
// ----------------------------------------------------------------------------
// lkp_pkg - shared codes and control bundles
// Operation and status codes of the per-key list pool, and the control
// bundles passed from the sequencer to the head and entry memories.
// ----------------------------------------------------------------------------
package lkp_pkg;

    // operation codes carried on the opcode field
    localparam logic [1:0] OP_REGISTER = 2'd0;
    localparam logic [1:0] OP_REMOVE   = 2'd1;
    localparam logic [1:0] OP_EXISTS   = 2'd2;
    localparam logic [1:0] OP_DEGREE   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RANGE     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // list head memory control
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } head_ctl_t;

    // entry memory control; item and link writes share one address
    typedef struct packed {
        logic rd_en;
        logic link_we;
        logic item_we;
    } pool_ctl_t;

endpackage

### rtl/lkp_head.sv
// ----------------------------------------------------------------------------
// lkp_head - list head memory
// One head pointer per key. After reset a clearing pass writes the null
// code into every entry, one entry a cycle, and reports busy meanwhile.
// ----------------------------------------------------------------------------
module lkp_head import lkp_pkg::*; #(
    parameter int MAX_NODES = 4096,
    parameter int NODE_BITS = 12,
    parameter int LINK_BITS = 15,
    parameter int NULL_CODE = 16384
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  head_ctl_t            ctl,
    input  logic [NODE_BITS-1:0] rd_addr,
    input  logic [NODE_BITS-1:0] wr_addr,
    input  logic [LINK_BITS-1:0] wr_data,
    output logic [LINK_BITS-1:0] rd_data,
    output logic                 busy
);

    logic [LINK_BITS-1:0] head_mem_reg [MAX_NODES];
    logic [LINK_BITS-1:0] rd_data_reg;
    logic                 busy_reg;
    logic                 busy_next;
    logic [NODE_BITS-1:0] clear_addr_reg;
    logic [NODE_BITS-1:0] clear_addr_next;
    logic                 mem_we;
    logic [NODE_BITS-1:0] mem_waddr;
    logic [LINK_BITS-1:0] mem_wdata;

    // clearing pass sequencing
    always_comb
    begin
        busy_next       = busy_reg;
        clear_addr_next = clear_addr_reg;
        if (busy_reg)
        begin
            clear_addr_next = clear_addr_reg + NODE_BITS'(1);
            if (clear_addr_reg == NODE_BITS'(MAX_NODES - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b1;
            clear_addr_reg <= '0;
        end
        else
        begin
            busy_reg       <= busy_next;
            clear_addr_reg <= clear_addr_next;
        end
    end

    // write port: clearing pass has priority, the sequencer is idle then
    assign mem_we    = busy_reg || ctl.wr_en;
    assign mem_waddr = busy_reg ? clear_addr_reg : wr_addr;
    assign mem_wdata = busy_reg ? LINK_BITS'(NULL_CODE) : wr_data;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            head_mem_reg[mem_waddr] <= mem_wdata;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= head_mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

### rtl/lkp_pool.sv
// ----------------------------------------------------------------------------
// lkp_pool - entry memories
// Item value and link of every pool entry. A high-water mark stands in for
// the initial chain: an entry never written links to the next entry, so the
// link memory needs no clearing pass.
// ----------------------------------------------------------------------------
module lkp_pool import lkp_pkg::*; #(
    parameter int POOL_ENTRIES = 16384,
    parameter int ITEM_BITS    = 24,
    parameter int PADDR_BITS   = 14,
    parameter int LINK_BITS    = 15
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pool_ctl_t             ctl,
    input  logic [PADDR_BITS-1:0] rd_addr,
    input  logic [PADDR_BITS-1:0] wr_addr,
    input  logic [LINK_BITS-1:0]  link_wr_data,
    input  logic [ITEM_BITS-1:0]  item_wr_data,
    output logic [ITEM_BITS-1:0]  rd_item,
    output logic [LINK_BITS-1:0]  rd_link
);

    logic [ITEM_BITS-1:0]  item_mem_reg [POOL_ENTRIES];
    logic [LINK_BITS-1:0]  link_mem_reg [POOL_ENTRIES];
    logic [ITEM_BITS-1:0]  rd_item_reg;
    logic [LINK_BITS-1:0]  rd_link_reg;
    logic [PADDR_BITS-1:0] rd_addr_reg;
    logic                  rd_fresh_reg;
    logic [LINK_BITS-1:0]  hw_reg;
    logic [LINK_BITS-1:0]  hw_next;
    logic                  wr_fresh;

    // high-water mark: entries below it have had their link written
    assign wr_fresh = LINK_BITS'(wr_addr) >= hw_reg;

    always_comb
    begin
        hw_next = hw_reg;
        if (ctl.link_we && wr_fresh)
        begin
            hw_next = LINK_BITS'(wr_addr) + LINK_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hw_reg <= '0;
        end
        else
        begin
            hw_reg <= hw_next;
        end
    end

    // memory ports, read data registered
    always_ff @(posedge clk)
    begin
        if (ctl.item_we)
        begin
            item_mem_reg[wr_addr] <= item_wr_data;
        end
        if (ctl.link_we)
        begin
            link_mem_reg[wr_addr] <= link_wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_item_reg  <= item_mem_reg[rd_addr];
            rd_link_reg  <= link_mem_reg[rd_addr];
            rd_addr_reg  <= rd_addr;
            rd_fresh_reg <= LINK_BITS'(rd_addr) >= hw_reg;
        end
    end

    // untouched entry: next entry, the last one gives the null code
    assign rd_link = rd_fresh_reg ? (LINK_BITS'(rd_addr_reg) + LINK_BITS'(1)) : rd_link_reg;
    assign rd_item = rd_item_reg;

endmodule

### rtl/lkp_seq.sv
// ----------------------------------------------------------------------------
// lkp_seq - operation sequencer
// Takes one transaction at a time, walks the key's list one entry a cycle
// through the entry memory using a shared item comparator and step counter,
// updates the lists and the free list, and holds the result register.
// ----------------------------------------------------------------------------
module lkp_seq import lkp_pkg::*; #(
    parameter int MAX_NODES    = 4096,
    parameter int POOL_ENTRIES = 16384,
    parameter int ITEM_BITS    = 24,
    parameter int NODE_BITS    = 12,
    parameter int CNT_BITS     = 13,
    parameter int PADDR_BITS   = 14,
    parameter int LINK_BITS    = 15
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  clear_busy,
    input  logic [CNT_BITS-1:0]   node_count,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            opcode,
    input  logic [NODE_BITS-1:0]  node,
    input  logic [ITEM_BITS-1:0]  item,
    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output logic                  found,
    output logic [LINK_BITS-1:0]  degree,
    // head memory
    output head_ctl_t             head_ctl,
    output logic [NODE_BITS-1:0]  head_rd_addr,
    output logic [NODE_BITS-1:0]  head_wr_addr,
    output logic [LINK_BITS-1:0]  head_wr_data,
    input  logic [LINK_BITS-1:0]  head_rd_data,
    // entry memory
    output pool_ctl_t             pool_ctl,
    output logic [PADDR_BITS-1:0] pool_rd_addr,
    output logic [PADDR_BITS-1:0] pool_wr_addr,
    output logic [LINK_BITS-1:0]  pool_link_wr_data,
    output logic [ITEM_BITS-1:0]  pool_item_wr_data,
    input  logic [ITEM_BITS-1:0]  pool_rd_item,
    input  logic [LINK_BITS-1:0]  pool_rd_link
);

    localparam logic [LINK_BITS-1:0] NIL = LINK_BITS'(POOL_ENTRIES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_ALLOC,
        S_WALK,
        S_UNLINK,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [1:0]           op_reg, op_next;
    logic [NODE_BITS-1:0] node_reg, node_next;
    logic [ITEM_BITS-1:0] item_reg, item_next;
    logic                 oor_reg, oor_next;
    logic [LINK_BITS-1:0] free_head_reg, free_head_next;
    logic [LINK_BITS-1:0] cur_reg, cur_next;
    logic [LINK_BITS-1:0] prev_reg, prev_next;
    logic [LINK_BITS-1:0] nxt_reg, nxt_next;
    logic [LINK_BITS-1:0] steps_reg, steps_next;
    logic [1:0]           res_status_reg, res_status_next;
    logic                 res_found_reg, res_found_next;
    logic [LINK_BITS-1:0] res_degree_reg, res_degree_next;
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           status_reg, status_next;
    logic                 found_reg, found_next;
    logic [LINK_BITS-1:0] degree_reg, degree_next;

    logic                 in_accept;
    logic                 in_range;
    logic                 item_match;
    logic [LINK_BITS-1:0] steps_inc;

    assign in_stall  = (state_reg != S_IDLE) || clear_busy;
    assign in_accept = in_valid && !in_stall;

    // key range: count clamped to 1..MAX_NODES, key 0 always in range
    assign in_range = ((node == '0) || (CNT_BITS'(node) < node_count))
                      && (CNT_BITS'(node) < CNT_BITS'(MAX_NODES));

    // shared comparator and step counter
    assign item_match = (pool_rd_item == item_reg);
    assign steps_inc  = steps_reg + LINK_BITS'(1);

    // sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        node_next       = node_reg;
        item_next       = item_reg;
        oor_next        = oor_reg;
        free_head_next  = free_head_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        nxt_next        = nxt_reg;
        steps_next      = steps_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_degree_next = res_degree_reg;
        status_next     = status_reg;
        found_next      = found_reg;
        degree_next     = degree_reg;
        out_valid_next  = out_valid_reg && out_stall;

        head_ctl          = '0;
        head_rd_addr      = node;
        head_wr_addr      = node_reg;
        head_wr_data      = free_head_reg;
        pool_ctl          = '0;
        pool_rd_addr      = cur_reg[PADDR_BITS-1:0];
        pool_wr_addr      = cur_reg[PADDR_BITS-1:0];
        pool_link_wr_data = free_head_reg;
        pool_item_wr_data = item_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    op_next      = opcode;
                    node_next    = node;
                    item_next    = item;
                    oor_next     = !in_range;
                    head_ctl.rd_en = 1'b1;
                    state_next   = S_HEAD;
                end
            end

            S_HEAD:
            begin
                steps_next      = '0;
                prev_next       = NIL;
                cur_next        = head_rd_data;
                res_status_next = ST_OK;
                res_found_next  = 1'b0;
                res_degree_next = '0;
                if (oor_reg)
                begin
                    res_status_next = ST_RANGE;
                    state_next      = S_DONE;
                end
                else if (op_reg == OP_REGISTER)
                begin
                    if (free_head_reg == NIL)
                    begin
                        res_status_next = ST_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        pool_ctl.rd_en = 1'b1;
                        pool_rd_addr   = free_head_reg[PADDR_BITS-1:0];
                        state_next     = S_ALLOC;
                    end
                end
                else if (head_rd_data == NIL)
                begin
                    if (op_reg == OP_REMOVE)
                    begin
                        res_status_next = ST_NOT_FOUND;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    pool_ctl.rd_en = 1'b1;
                    pool_rd_addr   = head_rd_data[PADDR_BITS-1:0];
                    state_next     = S_WALK;
                end
            end

            // push the first free entry onto the key's list
            S_ALLOC:
            begin
                pool_ctl.link_we  = 1'b1;
                pool_ctl.item_we  = 1'b1;
                pool_wr_addr      = free_head_reg[PADDR_BITS-1:0];
                pool_link_wr_data = head_rd_data;
                head_ctl.wr_en    = 1'b1;
                head_wr_data      = free_head_reg;
                free_head_next    = pool_rd_link;
                state_next        = S_DONE;
            end

            // one list entry a cycle
            S_WALK:
            begin
                steps_next = steps_inc;
                if ((op_reg != OP_DEGREE) && item_match)
                begin
                    if (op_reg == OP_REMOVE)
                    begin
                        // matched entry goes back on the free list
                        pool_ctl.link_we  = 1'b1;
                        pool_link_wr_data = free_head_reg;
                        free_head_next    = cur_reg;
                        if (prev_reg == NIL)
                        begin
                            head_ctl.wr_en = 1'b1;
                            head_wr_data   = pool_rd_link;
                            state_next     = S_DONE;
                        end
                        else
                        begin
                            nxt_next   = pool_rd_link;
                            state_next = S_UNLINK;
                        end
                    end
                    else
                    begin
                        res_found_next = 1'b1;
                        state_next     = S_DONE;
                    end
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = pool_rd_link;
                    if ((pool_rd_link == NIL) || (steps_inc == LINK_BITS'(POOL_ENTRIES)))
                    begin
                        if (op_reg == OP_REMOVE)
                        begin
                            res_status_next = ST_NOT_FOUND;
                        end
                        if (op_reg == OP_DEGREE)
                        begin
                            res_degree_next = steps_inc;
                        end
                        state_next = S_DONE;
                    end
                    else
                    begin
                        pool_ctl.rd_en = 1'b1;
                        pool_rd_addr   = pool_rd_link[PADDR_BITS-1:0];
                    end
                end
            end

            // predecessor now skips the removed entry
            S_UNLINK:
            begin
                pool_ctl.link_we  = 1'b1;
                pool_wr_addr      = prev_reg[PADDR_BITS-1:0];
                pool_link_wr_data = nxt_reg;
                state_next        = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    found_next     = res_found_reg;
                    degree_next    = res_degree_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state, working registers and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        node_reg       <= node_next;
        item_reg       <= item_next;
        oor_reg        <= oor_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        nxt_reg        <= nxt_next;
        steps_reg      <= steps_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_degree_reg <= res_degree_next;
        status_reg     <= status_next;
        found_reg      <= found_next;
        degree_reg     <= degree_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign found     = found_reg;
    assign degree    = degree_reg;

    // allocation never takes the null entry
    a_alloc_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ALLOC |-> free_head_reg != NIL)
        else $error("allocation from an empty free list");

    // a register with an empty free list reports pool full
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HEAD && !oor_reg && op_reg == OP_REGISTER && free_head_reg == NIL)
        |=> res_status_reg == ST_FULL)
        else $error("full pool not reported");

    // clearing pass keeps the input closed
    a_clear_block: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> in_stall)
        else $error("transaction accepted during clearing pass");

    // found answer only on a successful result with no count
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && found_reg) |-> (status_reg == ST_OK && degree_reg == '0))
        else $error("found set on an inconsistent result");

    // walk bounded by the pool size
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> steps_reg < LINK_BITS'(POOL_ENTRIES))
        else $error("list walk ran past the pool size");

endmodule

### rtl/per_key_linked_list_pool_core.sv
// ----------------------------------------------------------------------------
// per_key_linked_list_pool_core - per-key linked lists in a shared pool
// One singly linked list of item values per key, entries drawn from a fixed
// pool chained on a free list. Register, remove, exists and degree.
// ----------------------------------------------------------------------------
// One transaction is worked at a time. Register passes from accept to
// result through head read, free entry read, write-back and result load;
// remove, exists and degree read the head, visit the list entries one by
// one and load the result, and a remove whose match has a predecessor
// adds an unlink step. The walk is set by the single read port of the
// entry memory, one entry a cycle. A result waits in the output register
// while the next transaction is accepted. After reset a clearing pass
// empties every list head, and no transaction is accepted until it ends;
// node_count may be written at any time meanwhile.
module per_key_linked_list_pool_core import lkp_pkg::*; #(
    parameter int MAX_NODES    = 4096,
    parameter int POOL_ENTRIES = 16384,
    parameter int ITEM_BITS    = 24,
    parameter int NODE_BITS    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
    parameter int CNT_BITS     = $clog2(MAX_NODES + 1),
    parameter int PADDR_BITS   = $clog2(POOL_ENTRIES),
    parameter int LINK_BITS    = $clog2(POOL_ENTRIES + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_wr_en,
    input  logic [CNT_BITS-1:0]  cfg_wr_data,
    // input channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           opcode,
    input  logic [NODE_BITS-1:0] node,
    input  logic [ITEM_BITS-1:0] item,
    // output channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           status,
    output logic                 found,
    output logic [LINK_BITS-1:0] degree
);

    logic [CNT_BITS-1:0]   node_count_reg;
    logic [CNT_BITS-1:0]   node_count_next;

    head_ctl_t             head_ctl;
    logic [NODE_BITS-1:0]  head_rd_addr;
    logic [NODE_BITS-1:0]  head_wr_addr;
    logic [LINK_BITS-1:0]  head_wr_data;
    logic [LINK_BITS-1:0]  head_rd_data;
    logic                  clear_busy;

    pool_ctl_t             pool_ctl;
    logic [PADDR_BITS-1:0] pool_rd_addr;
    logic [PADDR_BITS-1:0] pool_wr_addr;
    logic [LINK_BITS-1:0]  pool_link_wr_data;
    logic [ITEM_BITS-1:0]  pool_item_wr_data;
    logic [ITEM_BITS-1:0]  pool_rd_item;
    logic [LINK_BITS-1:0]  pool_rd_link;

    // key count register
    assign node_count_next = cfg_wr_en ? cfg_wr_data : node_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= CNT_BITS'(MAX_NODES);
        end
        else
        begin
            node_count_reg <= node_count_next;
        end
    end

    lkp_head #(
        .MAX_NODES (MAX_NODES),
        .NODE_BITS (NODE_BITS),
        .LINK_BITS (LINK_BITS),
        .NULL_CODE (POOL_ENTRIES)
    ) u_head (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (head_ctl),
        .rd_addr (head_rd_addr),
        .wr_addr (head_wr_addr),
        .wr_data (head_wr_data),
        .rd_data (head_rd_data),
        .busy    (clear_busy)
    );

    lkp_pool #(
        .POOL_ENTRIES (POOL_ENTRIES),
        .ITEM_BITS    (ITEM_BITS),
        .PADDR_BITS   (PADDR_BITS),
        .LINK_BITS    (LINK_BITS)
    ) u_pool (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (pool_ctl),
        .rd_addr      (pool_rd_addr),
        .wr_addr      (pool_wr_addr),
        .link_wr_data (pool_link_wr_data),
        .item_wr_data (pool_item_wr_data),
        .rd_item      (pool_rd_item),
        .rd_link      (pool_rd_link)
    );

    lkp_seq #(
        .MAX_NODES    (MAX_NODES),
        .POOL_ENTRIES (POOL_ENTRIES),
        .ITEM_BITS    (ITEM_BITS),
        .NODE_BITS    (NODE_BITS),
        .CNT_BITS     (CNT_BITS),
        .PADDR_BITS   (PADDR_BITS),
        .LINK_BITS    (LINK_BITS)
    ) u_seq (
        .clk               (clk),
        .rst_n             (rst_n),
        .clear_busy        (clear_busy),
        .node_count        (node_count_reg),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .opcode            (opcode),
        .node              (node),
        .item              (item),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .status            (status),
        .found             (found),
        .degree            (degree),
        .head_ctl          (head_ctl),
        .head_rd_addr      (head_rd_addr),
        .head_wr_addr      (head_wr_addr),
        .head_wr_data      (head_wr_data),
        .head_rd_data      (head_rd_data),
        .pool_ctl          (pool_ctl),
        .pool_rd_addr      (pool_rd_addr),
        .pool_wr_addr      (pool_wr_addr),
        .pool_link_wr_data (pool_link_wr_data),
        .pool_item_wr_data (pool_item_wr_data),
        .pool_rd_item      (pool_rd_item),
        .pool_rd_link      (pool_rd_link)
    );

endmodule
